>>> hdl/sem_pkg.sv
// shared types, constants and helper functions for the sobel edge magnitude block
package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int PIX_W      = 24;
    localparam int SUM_W      = 21;
    localparam logic [SUM_W-1:0] ROOT_SAT_LIMIT = SUM_W'(65280);

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    // input item codes
    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } cmd_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } out_item_t;

    // 3x3 window, [row: top, mid, bottom][col: left, centre, right]
    typedef logic [2:0][2:0][PIX_W-1:0] window_t;

    typedef struct packed {
        window_t win;
        logic    frame_end;
    } job_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_PRD,
        F_PUPD,
        F_PJ1,
        F_PSHZ,
        F_PJ2,
        F_FRD0,
        F_FSH0,
        F_FRDN,
        F_FSHN,
        F_FJ
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQ,
        B_ROOT,
        B_RND,
        B_OUT
    } back_state_t;

    // shift a new column in on the right of the window
    function automatic window_t win_shift(window_t w, logic [PIX_W-1:0] top,
                                         logic [PIX_W-1:0] mid, logic [PIX_W-1:0] bot);
        window_t r;
        r = w;
        r[0][0] = w[0][1]; r[0][1] = w[0][2]; r[0][2] = top;
        r[1][0] = w[1][1]; r[1][1] = w[1][2]; r[1][2] = mid;
        r[2][0] = w[2][1]; r[2][1] = w[2][2]; r[2][2] = bot;
        return r;
    endfunction

    // gx*gx + gy*gy of one channel
    function automatic logic [SUM_W-1:0] grad_sq(window_t w, int unsigned ch);
        logic [9:0]         xp, xn, yp, yn;
        logic signed [10:0] gx, gy;
        logic signed [21:0] gx2, gy2;
        xp = 10'(w[0][2][8*ch +: 8]) + {1'b0, w[1][2][8*ch +: 8], 1'b0}
           + 10'(w[2][2][8*ch +: 8]);
        xn = 10'(w[0][0][8*ch +: 8]) + {1'b0, w[1][0][8*ch +: 8], 1'b0}
           + 10'(w[2][0][8*ch +: 8]);
        yp = 10'(w[2][0][8*ch +: 8]) + {1'b0, w[2][1][8*ch +: 8], 1'b0}
           + 10'(w[2][2][8*ch +: 8]);
        yn = 10'(w[0][0][8*ch +: 8]) + {1'b0, w[0][1][8*ch +: 8], 1'b0}
           + 10'(w[0][2][8*ch +: 8]);
        gx  = signed'({1'b0, xp}) - signed'({1'b0, xn});
        gy  = signed'({1'b0, yp}) - signed'({1'b0, yn});
        gx2 = 22'(gx) * 22'(gx);
        gy2 = 22'(gy) * 22'(gy);
        return {1'b0, gx2[19:0]} + {1'b0, gy2[19:0]};
    endfunction

endpackage

>>> hdl/sem_front.sv
// front part: frame position tracking, line stores, window and job generation
module sem_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  sem_pkg::in_item_t     pixel,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                  job_push,
    input  logic                  job_full,
    output sem_pkg::job_t         job
);
    import sem_pkg::*;

    front_state_t state_reg, state_next;

    logic [FW_W-1:0]  fw_reg;
    logic [FH_W-1:0]  fh_reg;
    logic [ROW_W-1:0] row_reg, r_reg;
    logic [COL_W-1:0] col_reg, flush_reg, c_reg;
    logic             drain_reg;
    logic [PIX_W-1:0] px_reg;
    window_t          win_reg;

    logic [PIX_W-1:0] older_mem [MAX_WIDTH];
    logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
    logic [PIX_W-1:0] older_q, newer_q;
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;

    logic [FW_W-1:0]  w_eff, w_m1;
    logic [FH_W-1:0]  h_eff;
    logic [FW_W-1:0]  nx;
    logic             nx_in;
    logic             c_last;
    logic             accept, cfg_wr;
    logic [COL_W-1:0] col_clamp, flush_clamp;
    logic [PIX_W-1:0] top_px, mid_px;

    // clamped frame size
    always_comb
    begin
        if (fw_reg == '0)
            w_eff = FW_W'(1);
        else if (fw_reg > FW_W'(MAX_WIDTH))
            w_eff = FW_W'(MAX_WIDTH);
        else
            w_eff = fw_reg;
        if (fh_reg == '0)
            h_eff = FH_W'(1);
        else if (fh_reg > FH_W'(MAX_HEIGHT))
            h_eff = FH_W'(MAX_HEIGHT);
        else
            h_eff = fh_reg;
        w_m1        = w_eff - FW_W'(1);
        col_clamp   = ({1'b0, col_reg} >= w_eff) ? w_m1[COL_W-1:0] : col_reg;
        flush_clamp = ({1'b0, flush_reg} >= w_eff) ? w_m1[COL_W-1:0] : flush_reg;
        nx          = {1'b0, c_reg} + FW_W'(1);
        nx_in       = nx < w_eff;
        c_last      = c_reg == w_m1[COL_W-1:0];
    end

    assign accept = push && !full;
    assign cfg_wr = cfg_valid && cfg_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept) begin
                    if (pixel.cmd == CMD_PIXEL && !drain_reg)
                        state_next = F_PRD;
                    else if (pixel.cmd == CMD_FLUSH && drain_reg)
                        state_next = (flush_clamp == '0) ? F_FRD0 : F_FRDN;
                end
            end
            F_PRD:  state_next = F_PUPD;
            F_PUPD: state_next = F_PJ1;
            F_PJ1:
            begin
                if (!(job_push && job_full))
                    state_next = c_last ? F_PSHZ : F_IDLE;
            end
            F_PSHZ: state_next = F_PJ2;
            F_PJ2:
            begin
                if (!(job_push && job_full))
                    state_next = F_IDLE;
            end
            F_FRD0: state_next = F_FSH0;
            F_FSH0: state_next = F_FRDN;
            F_FRDN: state_next = F_FSHN;
            F_FSHN: state_next = F_FJ;
            F_FJ:
            begin
                if (!job_full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    // outputs per state
    always_comb
    begin
        full      = state_reg != F_IDLE;
        cfg_ready = state_reg == F_IDLE;
        job_push  = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = c_reg;
        unique case (state_reg)
            F_PRD:
            begin
                rd_en = 1'b1;
            end
            F_PJ1:  job_push = (r_reg != '0) && (c_reg != '0);
            F_PJ2:  job_push = r_reg != '0;
            F_FRD0:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            F_FRDN:
            begin
                rd_en   = 1'b1;
                rd_addr = nx[COL_W-1:0];
            end
            F_FJ:   job_push = 1'b1;
            default: ;
        endcase
        job.win       = win_reg;
        job.frame_end = (state_reg == F_FJ) && c_last;
    end

    // line store reads and writes
    always_ff @(posedge clk)
    begin
        if (rd_en) begin
            older_q <= older_mem[rd_addr];
            newer_q <= newer_mem[rd_addr];
        end
        if (state_reg == F_PUPD) begin
            older_mem[c_reg] <= newer_q;
            newer_mem[c_reg] <= px_reg;
        end
    end

    // item latch
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && accept) begin
            px_reg <= {pixel.red_in, pixel.green_in, pixel.blue_in};
            r_reg  <= row_reg;
            c_reg  <= (pixel.cmd == CMD_FLUSH) ? flush_clamp : col_clamp;
        end
    end

    // window column sources
    always_comb
    begin
        if (state_reg == F_PUPD) begin
            top_px = (r_reg >= ROW_W'(2)) ? older_q : '0;
            mid_px = (r_reg != '0) ? newer_q : '0;
        end else begin
            top_px = (h_eff >= FH_W'(2)) ? older_q : '0;
            mid_px = newer_q;
        end
    end

    // control state, positions and window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= F_IDLE;
            fw_reg    <= FW_W'(640);
            fh_reg    <= FH_W'(480);
            row_reg   <= '0;
            col_reg   <= '0;
            flush_reg <= '0;
            drain_reg <= 1'b0;
            win_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT))
            begin
                if (cfg_index == CFG_FRAME_WIDTH)
                    fw_reg <= cfg_data[FW_W-1:0];
                else
                    fh_reg <= cfg_data;
                row_reg   <= '0;
                col_reg   <= '0;
                flush_reg <= '0;
                drain_reg <= 1'b0;
                win_reg   <= '0;
            end else begin
                unique case (state_reg)
                    F_PUPD:
                    begin
                        win_reg <= win_shift((c_reg == '0) ? window_t'('0) : win_reg,
                                             top_px, mid_px, px_reg);
                        if (c_last) begin
                            col_reg <= '0;
                            if ({1'b0, r_reg} + FH_W'(1) >= h_eff)
                                drain_reg <= 1'b1;
                            else
                                row_reg <= r_reg + ROW_W'(1);
                        end else begin
                            col_reg <= c_reg + COL_W'(1);
                        end
                    end
                    F_PSHZ: win_reg <= win_shift(win_reg, '0, '0, '0);
                    F_FSH0: win_reg <= win_shift(window_t'('0), top_px, mid_px, '0);
                    F_FSHN:
                    begin
                        if (nx_in)
                            win_reg <= win_shift(win_reg, top_px, mid_px, '0);
                        else
                            win_reg <= win_shift(win_reg, '0, '0, '0);
                    end
                    F_FJ:
                    begin
                        if (!job_full) begin
                            if (c_last) begin
                                row_reg   <= '0;
                                col_reg   <= '0;
                                flush_reg <= '0;
                                drain_reg <= 1'b0;
                                win_reg   <= '0;
                            end else begin
                                flush_reg <= c_reg + COL_W'(1);
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> hdl/sem_job_fifo.sv
// two-entry queue of window snapshots between the front and back parts
module sem_job_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  sem_pkg::job_t wr_data,
    output logic          full,
    input  logic          rd,
    output sem_pkg::job_t rd_data,
    output logic          empty
);
    import sem_pkg::*;

    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign rd_data = mem_reg[rp_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr && !full)
            mem_reg[wp_reg] <= wr_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr && !full)
                wp_reg <= !wp_reg;
            if (rd && !empty)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr && !full) - 2'(rd && !empty);
        end
    end

endmodule

>>> hdl/sem_back.sv
// back part: gradient squares, bit-serial rounded root and result queue
module sem_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_empty,
    output logic               job_pop,
    input  sem_pkg::job_t      job,
    output logic               empty,
    input  logic               pop,
    output sem_pkg::out_item_t result
);
    import sem_pkg::*;

    back_state_t state_reg, state_next;

    job_t             job_reg;
    logic [SUM_W-1:0] s_reg [3];
    logic [7:0]       n_reg [3];
    logic [7:0]       res_reg [3];
    logic [2:0]       bit_reg;

    out_item_t  q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       q_full, q_push;

    assign q_full = cnt_reg == 2'd2;
    assign empty  = cnt_reg == 2'd0;
    assign result = q_reg[rp_reg];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (!job_empty) state_next = B_SQ;
            B_SQ:   state_next = B_ROOT;
            B_ROOT: if (bit_reg == '0) state_next = B_RND;
            B_RND:  state_next = B_OUT;
            B_OUT:  if (!q_full) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // outputs per state
    always_comb
    begin
        job_pop = (state_reg == B_IDLE) && !job_empty;
        q_push  = (state_reg == B_OUT) && !q_full;
    end

    // datapath per channel
    always_ff @(posedge clk)
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            logic [7:0]  t;
            logic [15:0] tt;
            logic [16:0] nn;
            t  = n_reg[ch] | (8'd1 << bit_reg);
            tt = 16'(t) * 16'(t);
            nn = 17'(16'(n_reg[ch]) * 16'(n_reg[ch])) + 17'(n_reg[ch]);
            unique case (state_reg)
                B_SQ:
                begin
                    s_reg[ch] <= grad_sq(job_reg.win, ch);
                    n_reg[ch] <= '0;
                end
                B_ROOT:
                begin
                    if (SUM_W'(tt) <= s_reg[ch])
                        n_reg[ch] <= t;
                end
                B_RND:
                begin
                    if (s_reg[ch] > ROOT_SAT_LIMIT)
                        res_reg[ch] <= 8'd255;
                    else if (s_reg[ch] > SUM_W'(nn))
                        res_reg[ch] <= n_reg[ch] + 8'd1;
                    else
                        res_reg[ch] <= n_reg[ch];
                end
                default: ;
            endcase
        end
        if (job_pop)
            job_reg <= job;
        if (q_push)
            q_reg[wp_reg] <= '{red_out: res_reg[2], green_out: res_reg[1],
                               blue_out: res_reg[0], frame_end: job_reg.frame_end};
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= B_IDLE;
            bit_reg   <= 3'd7;
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            cnt_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_SQ)
                bit_reg <= 3'd7;
            else if (state_reg == B_ROOT)
                bit_reg <= bit_reg - 3'd1;
            if (q_push)
                wp_reg <= !wp_reg;
            if (pop && !empty)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(q_push) - 2'(pop && !empty);
        end
    end

endmodule

>>> hdl/sobel_edge_magnitude.sv
// top level: 3x3 sobel gradient magnitude per rgb channel on a raster pixel stream
// the front part latches a request, reads the line stores, shifts the window and
// pushes a job; it takes no new request before it is back in idle; the back part
// squares, runs its one-bit-a-cycle square root, rounds and queues a result per job
// reset: asynchronous active low; frame 640 x 480, positions and window cleared,
// line stores keep their contents and are not cleared
module sobel_edge_magnitude (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  sem_pkg::in_item_t             pixel,
    output logic                          empty,
    input  logic                          pop,
    output sem_pkg::out_item_t            result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sem_pkg::*;

    logic job_push, job_full, job_pop, job_empty;
    job_t job_in, job_out;

    // request classification and window building
    sem_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_push  (job_push),
        .job_full  (job_full),
        .job       (job_in)
    );

    // decoupling queue
    sem_job_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (job_push),
        .wr_data (job_in),
        .full    (job_full),
        .rd      (job_pop),
        .rd_data (job_out),
        .empty   (job_empty)
    );

    // magnitude computation
    sem_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .job       (job_out),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

>>> hdl/sem_checker.sv
// port-level checks for the sobel edge magnitude block and their binding
module sem_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input sem_pkg::out_item_t result,
    input logic               cfg_valid,
    input logic               cfg_ready
);
    import sem_pkg::*;

    // reset leaves no result and takes requests
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> empty && !full)
        else $error("block not idle during reset");

    // a register write never lands while a request is in work
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !full)
        else $error("register write during request");

    // a waiting result stays until popped
    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result lost");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(result))
        else $error("result changed before pop");

endmodule

bind sobel_edge_magnitude sem_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

>>> tb/sobel_edge_magnitude_test.sv
// self-checking testbench for the sobel edge magnitude block
`timescale 1ns / 1ps

module sobel_edge_magnitude_test;
    import sem_pkg::*;

    localparam int CYCLE_LIMIT  = 1500000;
    localparam int RANDOM_ITEMS = 1050;
    localparam int SETTLE       = 60;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    in_item_t              pixel;
    logic                  empty;
    logic                  pop;
    out_item_t             result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sobel_edge_magnitude dut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .pixel(pixel),
        .empty(empty), .pop(pop), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    in_item_t  pending_pixels[$];
    out_item_t expected_mags[$];
    int        mismatches;
    int        cycles;
    int        accepted;
    int        checked;
    int        frames_done;
    int        rx_hold;
    logic      hold_started;

    // shadow of the block's frame state
    logic [FW_W-1:0]  shadow_width;
    logic [FH_W-1:0]  shadow_height;
    logic [PIX_W-1:0] older_line[MAX_WIDTH];
    logic [PIX_W-1:0] newer_line[MAX_WIDTH];
    logic [PIX_W-1:0] win[3][3];
    int unsigned      row_pos;
    int unsigned      col_pos;
    int unsigned      flush_pos;
    logic             draining;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned active_width();
        if (shadow_width < 1) return 1;
        if (shadow_width > MAX_WIDTH) return MAX_WIDTH;
        return shadow_width;
    endfunction

    function automatic int unsigned active_height();
        if (shadow_height < 1) return 1;
        if (shadow_height > MAX_HEIGHT) return MAX_HEIGHT;
        return shadow_height;
    endfunction

    task automatic restart_frame();
        row_pos   = 0;
        col_pos   = 0;
        flush_pos = 0;
        draining  = 1'b0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = '0;
    endtask

    task automatic shift_column(logic [PIX_W-1:0] top, logic [PIX_W-1:0] mid,
                                logic [PIX_W-1:0] bot);
        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = bot;
    endtask

    // rounded square root of the gradient energy, saturated
    function automatic logic [7:0] channel_mag(int sh);
        int gx, gy, s, n, t;
        gx = (int'(win[0][2][sh +: 8]) + 2 * int'(win[1][2][sh +: 8]) + int'(win[2][2][sh +: 8]))
           - (int'(win[0][0][sh +: 8]) + 2 * int'(win[1][0][sh +: 8]) + int'(win[2][0][sh +: 8]));
        gy = (int'(win[2][0][sh +: 8]) + 2 * int'(win[2][1][sh +: 8]) + int'(win[2][2][sh +: 8]))
           - (int'(win[0][0][sh +: 8]) + 2 * int'(win[0][1][sh +: 8]) + int'(win[0][2][sh +: 8]));
        s = gx * gx + gy * gy;
        if (s > 65280) return 8'd255;
        n = 0;
        for (int b = 128; b != 0; b = b >> 1)
        begin
            t = n | b;
            if (t * t <= s) n = t;
        end
        if (s > n * n + n) n++;
        return (n > 255) ? 8'd255 : n[7:0];
    endfunction

    task automatic expect_mag(logic last);
        out_item_t o;
        o.red_out   = channel_mag(16);
        o.green_out = channel_mag(8);
        o.blue_out  = channel_mag(0);
        o.frame_end = last;
        expected_mags.push_back(o);
    endtask

    function automatic logic [PIX_W-1:0] flush_col(int unsigned k, int unsigned h, bit upper);
        if (upper) return (h >= 2) ? older_line[k] : '0;
        return newer_line[k];
    endfunction

    // expected results for one accepted request
    task automatic predict_request(in_item_t it);
        int unsigned w, h, c, r, f;
        logic [PIX_W-1:0] px, top, mid;
        w = active_width();
        h = active_height();
        if (it.cmd == CMD_PIXEL)
        begin
            if (draining) return;
            c = (col_pos >= w) ? w - 1 : col_pos;
            r = row_pos;
            px = {it.red_in, it.green_in, it.blue_in};
            if (c == 0) restart_window();
            top = (r >= 2) ? older_line[c] : '0;
            mid = (r >= 1) ? newer_line[c] : '0;
            shift_column(top, mid, px);
            older_line[c] = newer_line[c];
            newer_line[c] = px;
            if (r >= 1)
            begin
                if (c >= 1) expect_mag(1'b0);
                if (c == w - 1)
                begin
                    shift_column('0, '0, '0);
                    expect_mag(1'b0);
                end
            end
            if (c == w - 1)
            begin
                col_pos = 0;
                if (r + 1 >= h) draining = 1'b1;
                else row_pos = r + 1;
            end
            else
                col_pos = c + 1;
        end
        else
        begin
            if (!draining) return;
            f = (flush_pos >= w) ? w - 1 : flush_pos;
            if (f == 0)
            begin
                restart_window();
                shift_column(flush_col(0, h, 1), flush_col(0, h, 0), '0);
            end
            if (f + 1 < w) shift_column(flush_col(f + 1, h, 1), flush_col(f + 1, h, 0), '0);
            else shift_column('0, '0, '0);
            if (f == w - 1)
            begin
                expect_mag(1'b1);
                restart_frame();
            end
            else
            begin
                expect_mag(1'b0);
                flush_pos = f + 1;
            end
        end
    endtask

    task automatic restart_window();
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = '0;
    endtask

    // ~28 percent idle, except for a calm stretch of requests
    function automatic bit idle_now();
        if (accepted >= 500 && accepted < 800) return 1'b0;
        return $urandom_range(99) < 28;
    endfunction

    // sender: one request at a time from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push  <= 1'b0;
            pixel <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_request(pending_pixels.pop_front());
                accepted++;
            end
            if (pending_pixels.size() == 0 || idle_now())
                push <= 1'b0;
            else
            begin
                push  <= 1'b1;
                pixel <= pending_pixels[0];
            end
        end
    end

    // long receiver hold so the block backs up
    always @(posedge clk)
    begin
        if (rst_n && !hold_started && accepted >= 300)
        begin
            hold_started <= 1'b1;
            rx_hold      <= 600;
        end
        else if (rx_hold > 0)
            rx_hold <= rx_hold - 1;
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_mags.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", result);
                end
                else
                begin
                    out_item_t e;
                    e = expected_mags.pop_front();
                    checked++;
                    if (result.red_out !== e.red_out || result.green_out !== e.green_out ||
                        result.blue_out !== e.blue_out || result.frame_end !== e.frame_end)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected r%0d g%0d b%0d end%0d, got r%0d g%0d b%0d end%0d",
                                     e.red_out, e.green_out, e.blue_out, e.frame_end,
                                     result.red_out, result.green_out, result.blue_out,
                                     result.frame_end);
                    end
                end
            end
            pop <= (rx_hold == 0) && !idle_now();
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("sobel_edge_magnitude_test NOT OK");
            $finish;
        end
    end

    task automatic wait_drained();
        @(posedge clk);
        while (pending_pixels.size() != 0 || expected_mags.size() != 0 || push)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_FRAME_WIDTH) shadow_width = val[FW_W-1:0];
        else shadow_height = val[FH_W-1:0];
        restart_frame();
    endtask

    function automatic logic [7:0] rand_level();
        int k;
        k = $urandom_range(9);
        if (k < 2) return 8'd0;
        if (k < 4) return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    function automatic in_item_t make_req(cmd_t c);
        in_item_t it;
        it.cmd      = c;
        it.red_in   = rand_level();
        it.green_in = rand_level();
        it.blue_in  = rand_level();
        return it;
    endfunction

    // one frame with stray requests that the block must ignore
    task automatic queue_frame(logic [FW_W-1:0] wr, logic [FH_W-1:0] hr, int noise_pct,
                               inout int count);
        int unsigned w, h;
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(wr));
        write_reg(CFG_FRAME_HEIGHT, hr);
        w = active_width();
        h = active_height();
        for (int i = 0; i < w * h; i++)
        begin
            if ($urandom_range(99) < noise_pct) pending_pixels.push_back(make_req(CMD_FLUSH));
            pending_pixels.push_back(make_req(CMD_PIXEL));
            count++;
        end
        for (int i = 0; i < w; i++)
        begin
            if ($urandom_range(99) < noise_pct) pending_pixels.push_back(make_req(CMD_PIXEL));
            pending_pixels.push_back(make_req(CMD_FLUSH));
            count++;
        end
        wait_drained();
        frames_done++;
    endtask

    // stimulus
    initial
    begin
        int n;
        in_item_t it;
        n = 0;
        mismatches = 0; cycles = 0; accepted = 0; checked = 0; frames_done = 0;
        rx_hold = 0; hold_started = 1'b0;
        cfg_valid = 1'b0; cfg_index = CFG_FRAME_WIDTH; cfg_data = '0;
        shadow_width = 11'd640; shadow_height = 13'd480;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            older_line[i] = '0;
            newer_line[i] = '0;
        end
        restart_frame();
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (5) @(posedge clk);

        // directed: saturating 3x3 with stray requests on both sides
        write_reg(CFG_FRAME_WIDTH, 13'd3);
        write_reg(CFG_FRAME_HEIGHT, 13'd3);
        pending_pixels.push_back('{CMD_FLUSH, 8'hff, 8'hff, 8'hff});
        for (int i = 0; i < 9; i++)
        begin
            it.cmd = CMD_PIXEL;
            it.red_in = (i % 3 == 0) ? 8'hff : 8'h00;
            it.green_in = (i < 3) ? 8'hff : 8'h00;
            it.blue_in = (i % 2) ? 8'hff : 8'h00;
            pending_pixels.push_back(it);
        end
        pending_pixels.push_back('{CMD_PIXEL, 8'h55, 8'haa, 8'h01});
        for (int i = 0; i < 3; i++) pending_pixels.push_back('{CMD_FLUSH, 8'h00, 8'h00, 8'h00});
        wait_drained();
        frames_done++;

        // directed: smallest frames and width of one
        queue_frame(11'd1, 13'd1, 0, n);
        queue_frame(11'd2, 13'd1, 0, n);
        queue_frame(11'd1, 13'd3, 0, n);
        // zero width and height clamp to one
        queue_frame(11'd0, 13'd0, 0, n);
        queue_frame(11'd3, 13'd0, 0, n);

        // random frames, mostly small
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            if ($urandom_range(9) == 0)
                queue_frame(11'($urandom_range(64, 17)), 13'($urandom_range(4, 1)), 8, n);
            else
                queue_frame(11'($urandom_range(16, 1)), 13'($urandom_range(10, 1)), 8, n);
        end

        $display("%0d frames, %0d requests accepted, %0d results checked, %0d mismatches",
                 frames_done, accepted, checked, mismatches);
        if (mismatches == 0)
            $display("sobel_edge_magnitude_test OK");
        else
            $display("sobel_edge_magnitude_test NOT OK");
        $finish;
    end

endmodule

>>> sobel_edge_magnitude.f
hdl/sem_pkg.sv
hdl/sem_front.sv
hdl/sem_job_fifo.sv
hdl/sem_back.sv
hdl/sobel_edge_magnitude.sv
hdl/sem_checker.sv
tb/sobel_edge_magnitude_test.sv
